@@ rtl/pht_pkg.sv @@
// shared types and helpers for the pose to homogeneous transform block
// no dependencies
`default_nettype none
package pht_pkg;
    localparam int QW = 32;
    localparam int PW = 64;
    localparam int NW = 66;

    typedef struct packed {
        logic signed [QW-1:0] tx;
        logic signed [QW-1:0] ty;
        logic signed [QW-1:0] tz;
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
    } t_item;

    // one classified item waiting for the divider back end
    typedef struct packed {
        t_item      item;
        logic       zero;
    } t_job;
endpackage
`default_nettype wire

@@ rtl/pht_front.sv @@
// front end: accepts items, flags zero-norm quaternions, feeds the job queue
// depends on pht_pkg
`default_nettype none
module pht_front
    import pht_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  wire        i_ready,
    output t_job       o_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_job           r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           wr, rd;
    t_job           job;

    assign job.item = i_item;
    assign job.zero = (i_item.qw == '0) && (i_item.qx == '0) && (i_item.qy == '0)
                      && (i_item.qz == '0);
    assign o_ready  = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_job    = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

@@ rtl/pht_back.sv @@
// back end: products, numerators, nine bit-serial dividers, row output register
// depends on pht_pkg
`default_nettype none
module pht_back
    import pht_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  t_job              i_job,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [1:0]        o_row_index,
    output logic signed [31:0] o_col_first,
    output logic signed [31:0] o_col_second,
    output logic signed [31:0] o_col_third,
    output logic signed [31:0] o_row_trans,
    output logic              o_last_row,
    output logic              o_ok
);
    localparam int KMAX = FRAC_BITS + 2;
    localparam int CW = $clog2(KMAX + 4);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_SUM = 5'b00100,
        S_DIV = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_st;
    t_job   r_job;
    logic signed [PW-1:0] r_p [10];
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_r [9];
    logic [KMAX+1:0] r_q [9];
    logic [8:0] r_neg;
    logic [CW-1:0] r_cnt;
    logic [1:0] r_row;
    logic [31:0] ent [9];

    // outputs register
    logic        r_ov;
    logic [1:0]  r_ri;
    logic [31:0] r_c0, r_c1, r_c2, r_t;
    logic        r_lr, r_ok;

    function automatic logic [NW:0] smc(input logic signed [PW-1:0] a,
                                        input logic signed [PW-1:0] b, input logic sub);
        logic signed [NW-1:0] s;
        s = sub ? ($signed({{2{a[PW-1]}}, a}) - $signed({{2{b[PW-1]}}, b}))
                : ($signed({{2{a[PW-1]}}, a}) + $signed({{2{b[PW-1]}}, b}));
        smc = s[NW-1] ? {1'b1, -s} : {1'b0, s};
    endfunction

    function automatic logic [NW:0] ud(input logic [NW-1:0] a, input logic [NW-1:0] b);
        ud = (a >= b) ? {1'b0, a - b} : {1'b1, b - a};
    endfunction

    logic [NW-1:0] w2, x2, y2, z2, nsum;
    logic [NW:0] c [9];
    assign w2 = NW'(unsigned'(r_p[0]));
    assign x2 = NW'(unsigned'(r_p[1]));
    assign y2 = NW'(unsigned'(r_p[2]));
    assign z2 = NW'(unsigned'(r_p[3]));
    assign nsum = w2 + x2 + y2 + z2;
    always_comb begin
        c[0] = ud(w2 + x2, y2 + z2);
        c[4] = ud(w2 + y2, x2 + z2);
        c[8] = ud(w2 + z2, x2 + y2);
        // products: 4 xy, 5 wz, 6 xz, 7 wy, 8 yz, 9 wx
        c[1] = smc(r_p[4], r_p[5], 1'b1);
        c[2] = smc(r_p[6], r_p[7], 1'b0);
        c[3] = smc(r_p[4], r_p[5], 1'b0);
        c[5] = smc(r_p[8], r_p[9], 1'b1);
        c[6] = smc(r_p[6], r_p[7], 1'b1);
        c[7] = smc(r_p[8], r_p[9], 1'b0);
    end

    // off-diagonal entries take one extra quotient bit (factor 2)
    function automatic logic is_off(input int i);
        is_off = !(i == 0 || i == 4 || i == 8);
    endfunction

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            logic [KMAX+1:0] t;
            logic [KMAX+1:0] v;
            t = r_q[i];
            v = (t >> 1) + (KMAX+2)'(t[0]);
            if (v > (KMAX+2)'(32'h7fff_ffff)) v = (KMAX+2)'(32'h7fff_ffff);
            ent[i] = r_neg[i] ? (32'd0 - 32'(v)) : 32'(v);
        end
    end

    logic out_free;
    assign out_free = !r_ov || i_ready;
    assign o_ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: if (i_valid) r_job <= i_job;
            S_MUL: begin
                r_p[0] <= r_job.item.qw * r_job.item.qw;
                r_p[1] <= r_job.item.qx * r_job.item.qx;
                r_p[2] <= r_job.item.qy * r_job.item.qy;
                r_p[3] <= r_job.item.qz * r_job.item.qz;
                r_p[4] <= r_job.item.qx * r_job.item.qy;
                r_p[5] <= r_job.item.qw * r_job.item.qz;
                r_p[6] <= r_job.item.qx * r_job.item.qz;
                r_p[7] <= r_job.item.qw * r_job.item.qy;
                r_p[8] <= r_job.item.qy * r_job.item.qz;
                r_p[9] <= r_job.item.qw * r_job.item.qx;
            end
            S_SUM: begin
                // norm up to 2^64 fits in NW bits, no halving needed
                r_n <= nsum;
                for (int i = 0; i < 9; i++) begin
                    r_neg[i] <= c[i][NW] && (c[i][NW-1:0] != '0);
                    r_r[i] <= c[i][NW-1:0];
                    r_q[i] <= '0;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle; m <= 2n so
                // the integer part is at most 2 bits, covered by two extra steps
                for (int i = 0; i < 9; i++) begin
                    logic [NW:0] d2;
                    d2 = {r_r[i], 1'b0};
                    if (r_cnt < CW'(2)) begin
                        // integer part first: r holds m, compare with n<<(1-cnt)
                        if (r_cnt == '0) begin
                            if ({1'b0, r_r[i]} >= {r_n, 1'b0}) begin
                                r_r[i] <= r_r[i] - {r_n[NW-2:0], 1'b0};
                                r_q[i] <= {r_q[i][KMAX:0], 1'b1};
                            end else r_q[i] <= {r_q[i][KMAX:0], 1'b0};
                        end else begin
                            if (r_r[i] >= r_n) begin
                                r_r[i] <= r_r[i] - r_n;
                                r_q[i] <= {r_q[i][KMAX:0], 1'b1};
                            end else r_q[i] <= {r_q[i][KMAX:0], 1'b0};
                        end
                    end else if (r_cnt < CW'(KMAX + 2) &&
                                 (is_off(i) || r_cnt < CW'(KMAX + 1))) begin
                        if (d2 >= {1'b0, r_n}) begin
                            r_r[i] <= NW'(d2 - {1'b0, r_n});
                            r_q[i] <= {r_q[i][KMAX:0], 1'b1};
                        end else begin
                            r_r[i] <= d2[NW-1:0];
                            r_q[i] <= {r_q[i][KMAX:0], 1'b0};
                        end
                    end
                end
            end
            default: ;
        endcase
        if (out_free && r_st == S_OUT) begin
            r_lr <= r_job.zero || (r_row == 2'd2);
            r_ok <= !r_job.zero;
            if (r_job.zero) begin
                r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_t <= '0; r_ri <= 2'd0;
            end else begin
                r_ri <= r_row;
                r_t  <= (r_row == 2'd0) ? r_job.item.tx :
                        (r_row == 2'd1) ? r_job.item.ty : r_job.item.tz;
                r_c0 <= (r_row == 2'd0) ? ent[0] : (r_row == 2'd1) ? ent[3] : ent[6];
                r_c1 <= (r_row == 2'd0) ? ent[1] : (r_row == 2'd1) ? ent[4] : ent[7];
                r_c2 <= (r_row == 2'd0) ? ent[2] : (r_row == 2'd1) ? ent[5] : ent[8];
            end
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_cnt <= '0;
            r_row <= '0;
        end else begin
            if (r_st == S_OUT && out_free) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) r_st <= i_job.zero ? S_OUT : S_MUL;
                S_MUL:  r_st <= S_SUM;
                S_SUM: begin
                    r_st <= S_DIV;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(KMAX + 1)) begin
                        r_st <= S_OUT;
                        r_row <= '0;
                    end
                end
                S_OUT: if (out_free) begin
                    if (r_job.zero || r_row == 2'd2) begin
                        r_st <= S_IDLE;
                        r_row <= '0;
                    end else r_row <= r_row + 1'b1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_row_index = r_ri;
    assign o_col_first = r_c0;
    assign o_col_second = r_c1;
    assign o_col_third = r_c2;
    assign o_row_trans = r_t;
    assign o_last_row = r_lr;
    assign o_ok = r_ok;
endmodule
`default_nettype wire

@@ rtl/pose_to_homogeneous_transform_top.sv @@
// Pose to homogeneous transform: translation plus quaternion in, three
// rows of the 3x4 transform out (rotation entries Q(32-FRAC_BITS).FRAC_BITS,
// translation Q16.16).
// Channels: input and output valid/ready. A front end checks the quaternion
// for zero norm and queues the item in a two-entry queue; the back end
// forms the ten products, the numerators and the norm, then runs nine
// restoring dividers in parallel, one quotient bit per cycle.
// Rows follow one per cycle while the receiver is ready. The back end takes
// a new item only after the last row of the previous one; the front queue
// holds waiting items meanwhile. A zero-norm quaternion skips the divider
// and gives one row with ok low.
// Reset clears the queue, the sequencer and the output valid.
// A receiver stall holds the output register, and the sequencer waits in its
// output state; the front queue keeps accepting until full.
// depends on pht_pkg, pht_front, pht_back
`default_nettype none
module pose_to_homogeneous_transform_top
    import pht_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_trans_x,
    input  wire signed [31:0]  i_trans_y,
    input  wire signed [31:0]  i_trans_z,
    input  wire signed [31:0]  i_quat_w,
    input  wire signed [31:0]  i_quat_x,
    input  wire signed [31:0]  i_quat_y,
    input  wire signed [31:0]  i_quat_z,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col_first,
    output logic signed [31:0] o_col_second,
    output logic signed [31:0] o_col_third,
    output logic signed [31:0] o_row_trans,
    output logic               o_last_row,
    output logic               o_ok
);
    t_item item;
    t_job  job;
    logic  jv, jr;

    assign item = '{tx: i_trans_x, ty: i_trans_y, tz: i_trans_z,
                    qw: i_quat_w, qx: i_quat_x, qy: i_quat_y, qz: i_quat_z};

    pht_front #(.DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(item),
        .o_valid(jv), .i_ready(jr), .o_job(job)
    );

    pht_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(jv), .o_ready(jr), .i_job(job),
        .o_valid, .i_ready, .o_row_index, .o_col_first, .o_col_second,
        .o_col_third, .o_row_trans, .o_last_row, .o_ok
    );

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_last_row && o_row_index == 2'd0))
        else $error("failed item must be a single last row");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_index != 2'd3))
        else $error("row index out of range");
    a_last_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_last_row == (o_row_index == 2'd2)))
        else $error("last row flag mismatch");
endmodule
`default_nettype wire
